// File: hdl/lom_pkg.sv
// Shared types and codes for the limit order matcher.
package lom_pkg;

	localparam int SLOT_IDX_W = 6;

	typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

	typedef enum logic [0:0] {
		CMD_ADD    = 1'b0,
		CMD_CANCEL = 1'b1
	} command_t;

	typedef enum logic [2:0] {
		KIND_FILL      = 3'd0,
		KIND_RESTED    = 3'd1,
		KIND_DONE      = 3'd2,
		KIND_CANCELLED = 3'd3,
		KIND_ERROR     = 3'd4
	} result_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_SIZE  = 3'd1,
		ERR_BAD_PRICE = 3'd2,
		ERR_DUPLICATE = 3'd3,
		ERR_NOT_FOUND = 3'd4,
		ERR_BOOK_FULL = 3'd5
	} error_code_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_CLEAR,
		WR_REDUCE,
		WR_LOAD
	} wr_op_t;

	typedef struct packed {
		logic        command;
		logic [31:0] order_ident;
		logic        buy_sell;
		logic        market_kind;
		logic [31:0] limit_ticks;
		logic [31:0] order_size;
		logic [63:0] arrival_stamp;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [2:0]  error_code;
		logic [63:0] execution_number;
		logic [31:0] aggressor_ident;
		logic [31:0] entry_ident;
		logic        entry_side;
		logic [31:0] entry_price;
		logic [31:0] entry_size;
		logic [63:0] entry_stamp;
		logic        last_result;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ident;
		logic        side;
		logic        market;
		logic [31:0] limit;
		logic [31:0] counter;
	} query_t;

	typedef struct packed {
		logic        dup_hit;
		slot_idx_t   dup_idx;
		logic        dup_side;
		logic [31:0] dup_price;
		logic [31:0] dup_rem;
		logic [63:0] dup_stamp;
		logic        best_hit;
		slot_idx_t   best_idx;
		logic [31:0] best_order;
		logic [31:0] top_price;
		logic [31:0] best_rem;
		logic [31:0] best_age;
		logic        free_hit;
		slot_idx_t   free_idx;
	} carry_t;

	typedef struct packed {
		wr_op_t      op;
		slot_idx_t   idx;
		logic [31:0] ident;
		logic        side;
		logic [31:0] price;
		logic [31:0] amount;
		logic [63:0] stamp;
		logic [31:0] sequence_no;
	} slot_wr_t;

endpackage

// File: hdl/lom_cell.sv
// One book slot: holds a resting order and folds it into the passing scan carry.
module lom_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lom_pkg::query_t   query,
	input  lom_pkg::slot_wr_t wr,
	input  lom_pkg::carry_t   carry_in,
	output lom_pkg::carry_t   carry_out
);

	logic        valid_q;
	logic [31:0] order_q;
	logic        side_q;
	logic [31:0] price_q;
	logic [31:0] rem_q;
	logic [63:0] stamp_q;
	logic [31:0] seq_q;
	lom_pkg::carry_t carry_q;
	lom_pkg::carry_t carry_d;

	logic        hit;
	logic [31:0] age;
	logic        eligible;
	logic        better;

	assign hit = (wr.idx == lom_pkg::slot_idx_t'(CELL_INDEX));
	assign age = query.counter - seq_q;

	always_comb begin
		eligible = valid_q && (side_q != query.side);
		if (!query.market) begin
			if (!query.side) begin
				eligible = eligible && (price_q <= query.limit);
			end else begin
				eligible = eligible && (price_q >= query.limit);
			end
		end
		if (!carry_in.best_hit) begin
			better = 1'b1;
		end else if (!query.side) begin
			better = (price_q < carry_in.top_price) ||
				((price_q == carry_in.top_price) && (age > carry_in.best_age));
		end else begin
			better = (price_q > carry_in.top_price) ||
				((price_q == carry_in.top_price) && (age > carry_in.best_age));
		end
	end

	always_comb begin
		carry_d = carry_in;
		if (!carry_in.dup_hit && valid_q && (order_q == query.ident)) begin
			carry_d.dup_hit   = 1'b1;
			carry_d.dup_idx   = lom_pkg::slot_idx_t'(CELL_INDEX);
			carry_d.dup_side  = side_q;
			carry_d.dup_price = price_q;
			carry_d.dup_rem   = rem_q;
			carry_d.dup_stamp = stamp_q;
		end
		if (eligible && better) begin
			carry_d.best_hit   = 1'b1;
			carry_d.best_idx   = lom_pkg::slot_idx_t'(CELL_INDEX);
			carry_d.best_order = order_q;
			carry_d.top_price  = price_q;
			carry_d.best_rem   = rem_q;
			carry_d.best_age   = age;
		end
		if (!carry_in.free_hit && !valid_q) begin
			carry_d.free_hit = 1'b1;
			carry_d.free_idx = lom_pkg::slot_idx_t'(CELL_INDEX);
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= carry_d;
	end

	assign carry_out = carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit) begin
			unique case (wr.op)
				lom_pkg::WR_CLEAR:  valid_q <= 1'b0;
				lom_pkg::WR_REDUCE: valid_q <= (rem_q != wr.amount);
				lom_pkg::WR_LOAD:   valid_q <= 1'b1;
				default:            valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hit && (wr.op == lom_pkg::WR_REDUCE)) begin
			rem_q <= rem_q - wr.amount;
		end else if (hit && (wr.op == lom_pkg::WR_LOAD)) begin
			order_q <= wr.ident;
			side_q  <= wr.side;
			price_q <= wr.price;
			rem_q   <= wr.amount;
			stamp_q <= wr.stamp;
			seq_q   <= wr.sequence_no;
		end
	end

endmodule

// File: hdl/limit_order_matcher_top.sv
// Top level of the limit order matcher: slot chain, sequencer and result register.
//
//  channel | signals                  | beat
//  --------+--------------------------+-------------------------------
//  request | req_valid, req_ready, req | one add or cancel command
//  result  | rsp_valid, rsp_ready, rsp | one fill or final result
//
// Each scan walks the slot chain one cell per cycle and is followed by a decision
// state. A cancel or rejected add takes one scan and one decision; an add
// with F fills takes one scan and decision per fill plus a final scan and decision.
// Reset empties the book, clears the arrival counter and sets the execution id to one.
// A stalled result holds the decision cycle; a new command is taken while the last
// result still waits.
module limit_order_matcher_top #(
	parameter int ORDER_SLOTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lom_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lom_pkg::rsp_t rsp
);

	localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int FW = $clog2(ORDER_SLOTS + 1);

	lom_pkg::state_t   state_q, state_d;
	logic [IW-1:0]     scan_cnt_q;
	lom_pkg::req_t     item_q;
	logic [31:0]       rem_q;
	logic [FW-1:0]     fills_q;
	logic              first_q;
	logic [31:0]       counter_q;
	logic [63:0]       exec_q;
	logic              rsp_valid_q;
	lom_pkg::rsp_t     rsp_q;

	lom_pkg::query_t   query;
	lom_pkg::slot_wr_t wr;
	lom_pkg::carry_t   carry [ORDER_SLOTS];
	lom_pkg::carry_t   last;
	lom_pkg::rsp_t     rsp_d;
	logic              out_free;
	logic              emit;
	logic              match;
	logic              rest;
	logic [31:0]       trade;

	assign query = '{ident: item_q.order_ident, side: item_q.buy_sell,
		market: item_q.market_kind, limit: item_q.limit_ticks, counter: counter_q};

	for (genvar k = 0; k < ORDER_SLOTS; k++) begin : g_cell
		if (k == 0) begin : g_head
			lom_cell #(.CELL_INDEX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .query(query), .wr(wr),
				.carry_in('0), .carry_out(carry[k])
			);
		end else begin : g_link
			lom_cell #(.CELL_INDEX(k)) u_cell (
				.clk(clk), .arst_n(arst_n), .query(query), .wr(wr),
				.carry_in(carry[k-1]), .carry_out(carry[k])
			);
		end
	end

	assign last      = carry[ORDER_SLOTS-1];
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign emit      = (state_q == lom_pkg::ST_DECIDE) && out_free;
	assign req_ready = (state_q == lom_pkg::ST_IDLE);
	assign trade     = (rem_q < last.best_rem) ? rem_q : last.best_rem;

	always_comb begin
		match = 1'b0;
		rest  = 1'b0;
		if (item_q.command == lom_pkg::CMD_ADD) begin
			if (!(first_q && ((item_q.order_size == 32'd0) ||
				(!item_q.market_kind && (item_q.limit_ticks == 32'd0)) || last.dup_hit))) begin
				match = (rem_q != 32'd0) && (fills_q < FW'(ORDER_SLOTS)) && last.best_hit;
				rest  = !match && (rem_q != 32'd0) && !item_q.market_kind && last.free_hit;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lom_pkg::ST_IDLE: begin
				if (req_valid) state_d = lom_pkg::ST_SCAN;
			end
			lom_pkg::ST_SCAN: begin
				if (scan_cnt_q == IW'(ORDER_SLOTS - 1)) state_d = lom_pkg::ST_DECIDE;
			end
			lom_pkg::ST_DECIDE: begin
				if (emit) state_d = match ? lom_pkg::ST_SCAN : lom_pkg::ST_IDLE;
			end
			default: state_d = lom_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.entry_ident = item_q.order_ident;
		rsp_d.last_result = 1'b1;
		wr = '0;
		wr.op = lom_pkg::WR_NONE;
		if (item_q.command == lom_pkg::CMD_CANCEL) begin
			if (last.dup_hit) begin
				rsp_d.result_kind = lom_pkg::KIND_CANCELLED;
				rsp_d.entry_side  = last.dup_side;
				rsp_d.entry_price = last.dup_price;
				rsp_d.entry_size  = last.dup_rem;
				rsp_d.entry_stamp = last.dup_stamp;
				wr.op  = lom_pkg::WR_CLEAR;
				wr.idx = last.dup_idx;
			end else begin
				rsp_d.result_kind = lom_pkg::KIND_ERROR;
				rsp_d.error_code  = lom_pkg::ERR_NOT_FOUND;
			end
		end else if (first_q && (item_q.order_size == 32'd0)) begin
			rsp_d.result_kind = lom_pkg::KIND_ERROR;
			rsp_d.error_code  = lom_pkg::ERR_BAD_SIZE;
		end else if (first_q && !item_q.market_kind && (item_q.limit_ticks == 32'd0)) begin
			rsp_d.result_kind = lom_pkg::KIND_ERROR;
			rsp_d.error_code  = lom_pkg::ERR_BAD_PRICE;
		end else if (first_q && last.dup_hit) begin
			rsp_d.result_kind = lom_pkg::KIND_ERROR;
			rsp_d.error_code  = lom_pkg::ERR_DUPLICATE;
		end else if (match) begin
			rsp_d.result_kind      = lom_pkg::KIND_FILL;
			rsp_d.execution_number = exec_q;
			rsp_d.aggressor_ident  = item_q.order_ident;
			rsp_d.entry_ident      = last.best_order;
			rsp_d.entry_side       = item_q.buy_sell;
			rsp_d.entry_price      = last.top_price;
			rsp_d.entry_size       = trade;
			rsp_d.entry_stamp      = item_q.arrival_stamp;
			rsp_d.last_result      = 1'b0;
			wr.op     = lom_pkg::WR_REDUCE;
			wr.idx    = last.best_idx;
			wr.amount = trade;
		end else if ((rem_q == 32'd0) || item_q.market_kind) begin
			rsp_d.result_kind = lom_pkg::KIND_DONE;
			rsp_d.entry_side  = item_q.buy_sell;
			rsp_d.entry_price = item_q.market_kind ? 32'd0 : item_q.limit_ticks;
			rsp_d.entry_size  = rem_q;
			rsp_d.entry_stamp = item_q.arrival_stamp;
		end else if (rest) begin
			rsp_d.result_kind = lom_pkg::KIND_RESTED;
			rsp_d.entry_side  = item_q.buy_sell;
			rsp_d.entry_price = item_q.limit_ticks;
			rsp_d.entry_size  = rem_q;
			rsp_d.entry_stamp = item_q.arrival_stamp;
			wr.op          = lom_pkg::WR_LOAD;
			wr.idx         = last.free_idx;
			wr.ident       = item_q.order_ident;
			wr.side        = item_q.buy_sell;
			wr.price       = item_q.limit_ticks;
			wr.amount      = rem_q;
			wr.stamp       = item_q.arrival_stamp;
			wr.sequence_no = counter_q;
		end else begin
			rsp_d.result_kind = lom_pkg::KIND_ERROR;
			rsp_d.error_code  = lom_pkg::ERR_BOOK_FULL;
		end
		if (!emit) wr.op = lom_pkg::WR_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lom_pkg::ST_IDLE;
			scan_cnt_q  <= '0;
			fills_q     <= '0;
			first_q     <= 1'b0;
			counter_q   <= 32'd0;
			exec_q      <= 64'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lom_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end else begin
				scan_cnt_q <= '0;
			end
			if (req_valid && req_ready) begin
				fills_q <= '0;
				first_q <= 1'b1;
			end else if (emit) begin
				first_q <= 1'b0;
				if (match) begin
					fills_q <= fills_q + FW'(1);
					exec_q  <= exec_q + 64'd1;
				end
				if (rest) counter_q <= counter_q + 32'd1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
			rem_q  <= req.order_size;
		end else if (emit && match) begin
			rem_q <= rem_q - trade;
		end
		if (emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/lom_checker.sv
// Port checker for the limit order matcher, bound to the top level.
module lom_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input lom_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input lom_pkg::rsp_t rsp
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("command taken while busy");

	a_fill_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.result_kind == lom_pkg::KIND_FILL) != rsp.last_result))
		else $error("last flag disagrees with result kind");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.result_kind == lom_pkg::KIND_ERROR) |->
		(rsp.entry_size == 32'd0) && (rsp.execution_number == 64'd0) &&
		(rsp.error_code != lom_pkg::ERR_NONE))
		else $error("error result carries data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind limit_order_matcher_top lom_port_checker u_lom_port_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
